>>> sv/assert_macros.svh
// Assertion macros used by the gear hash chunker RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, c, r, a, b) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> sv/ghcc_pkg.sv
// Shared types and codes for the gear hash content chunker.
// No dependencies; imported by the cell, gear memory and top level.
`default_nettype none
package ghcc_pkg;
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_GEAR = 1'b1;

    localparam logic [2:0] CFG_MIN_SIZE    = 3'd0;
    localparam logic [2:0] CFG_MAX_SIZE    = 3'd1;
    localparam logic [2:0] CFG_WINDOW_SIZE = 3'd2;
    localparam logic [2:0] CFG_CUT_MASK    = 3'd3;

    typedef struct packed {
        logic [39:0] offset;
        logic [23:0] length;
        logic        fin;
        logic        last;
    } chunk_res_t;
endpackage
`default_nettype wire

>>> sv/gear_hash_content_chunker_core.sv
// A byte outside the cut search is closed out as it is accepted. A byte inside it passes
// through accept, gear lookup and roll, and once per chunk, at the minimum chunk size, the
// hash is first rebuilt by reading and adding the gear value of each window byte in turn.
// Gear writes are taken only while idle. Up to two chunk results per byte wait in a
// two-entry output queue, and a new item is taken only once it drains.
`default_nettype none
`include "assert_macros.svh"
module gear_hash_content_chunker_core
    import ghcc_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [7:0]  byte_value,
    input  wire logic        end_of_stream,
    input  wire logic [7:0]  gear_index,
    input  wire logic [31:0] gear_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [39:0] chunk_offset,
    output logic      [23:0] chunk_length,
    output logic             final_chunk,
    output logic             last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RB_RD  = 3'd1;
    localparam logic [2:0] S_RB_ACC = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_ROLL   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [23:0] min_len_reg, max_size_reg;
    logic [6:0]  window_size_reg;
    logic [31:0] cut_mask_reg;
    logic [31:0] hash_reg, hash_next;
    logic [23:0] n_reg, n_next;
    logic [39:0] start_reg, start_next;
    logic [IW-1:0] rb_cnt_reg, rb_cnt_next;
    logic [7:0]  byte_reg;
    logic        eos_reg;
    logic [1:0]  qv_reg;
    chunk_res_t  q0_reg, q1_reg;

    logic [7:0]  hist [MAX_WINDOW];
    logic [8:0]  ws9, w_eff;
    logic [IW-1:0] w_last;
    logic [23:0] mx;
    logic        in_acc, data_acc, gear_acc, out_acc;
    logic        case_a, scan, rebuild;
    logic        fin_go, pre_emit, post_emit, fin_eos;
    logic [7:0]  fin_byte, rd_a_addr;
    logic [23:0] n_base, n1;
    logic [39:0] start_b;
    logic [31:0] rd_a_data, rd_b_data;
    chunk_res_t  pre_res, post_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !qv_reg[0];
    assign in_acc    = in_valid && in_ready;
    assign data_acc  = in_acc && (req_type == REQ_DATA);
    assign gear_acc  = in_acc && (req_type == REQ_GEAR);
    assign out_valid = qv_reg[0];
    assign out_acc   = out_valid && out_ready;
    assign chunk_offset = q0_reg.offset;
    assign chunk_length = q0_reg.length;
    assign final_chunk  = q0_reg.fin;
    assign last_result  = q0_reg.last;

    // Effective window and max length.
    always_comb
    begin
        ws9 = {2'b00, window_size_reg};
        if (ws9 == 9'd0)
        begin
            w_eff = 9'd1;
        end
        else if (ws9 > 9'(MAX_WINDOW))
        begin
            w_eff = 9'(MAX_WINDOW);
        end
        else
        begin
            w_eff = ws9;
        end
        mx = (max_size_reg == 24'd0) ? 24'd1 : max_size_reg;
    end
    assign w_last = IW'(w_eff - 9'd1);

    // Decisions taken when a data byte arrives.
    assign case_a  = (n_reg != 24'd0) && (n_reg >= mx);
    assign scan    = !case_a && (min_len_reg >= {15'd0, w_eff}) && (n_reg >= min_len_reg);
    assign rebuild = scan && (n_reg == min_len_reg);

    assign fin_go   = (data_acc && !scan) || (state_reg == S_ROLL);
    assign pre_emit = (state_reg == S_ROLL) ? ((hash_reg & cut_mask_reg) == 32'd0) : case_a;
    assign fin_byte = (state_reg == S_ROLL) ? byte_reg : byte_value;
    assign fin_eos  = (state_reg == S_ROLL) ? eos_reg : end_of_stream;

    // Closing arithmetic for the byte that is appended.
    always_comb
    begin
        n_base    = pre_emit ? 24'd0 : n_reg;
        n1        = n_base + 24'd1;
        start_b   = pre_emit ? (start_reg + {16'd0, n_reg}) : start_reg;
        post_emit = fin_eos || (n1 >= mx);
        pre_res.offset  = start_reg;
        pre_res.length  = n_reg;
        pre_res.fin     = 1'b0;
        pre_res.last    = !post_emit;
        post_res.offset = start_b;
        post_res.length = n1;
        post_res.fin    = fin_eos;
        post_res.last   = 1'b1;
    end

    // Byte history as a chain of cells, newest at cell zero.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            logic [7:0] cell_in;
            if (gi == 0)
            begin : g_head
                assign cell_in = fin_byte;
            end
            else
            begin : g_link
                assign cell_in = hist[gi-1];
            end
            ghcc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (fin_go),
                .byte_in  (cell_in),
                .byte_out (hist[gi])
            );
        end
    endgenerate

    // Gear table reads: rebuild walks the window, roll needs new and old byte.
    assign rd_a_addr = (state_reg == S_LOOK) ? byte_reg : hist[rb_cnt_reg];

    ghcc_gear_ram u_gear (
        .clk       (clk),
        .wr_en     (gear_acc),
        .wr_addr   (gear_index),
        .wr_data   (gear_value),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (hist[w_last]),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        rb_cnt_next = rb_cnt_reg;
        n_next      = n_reg;
        start_next  = start_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (data_acc && rebuild)
                begin
                    state_next  = S_RB_RD;
                    hash_next   = 32'd0;
                    rb_cnt_next = w_last;
                end
                else if (data_acc && scan)
                begin
                    state_next = S_LOOK;
                end
            end
            S_RB_RD:
            begin
                state_next = S_RB_ACC;
            end
            S_RB_ACC:
            begin
                hash_next = (hash_reg << 1) + rd_a_data;
                if (rb_cnt_reg == '0)
                begin
                    state_next = S_LOOK;
                end
                else
                begin
                    rb_cnt_next = rb_cnt_reg - 1'b1;
                    state_next  = S_RB_RD;
                end
            end
            S_LOOK:
            begin
                state_next = S_ROLL;
            end
            S_ROLL:
            begin
                state_next = S_IDLE;
                if (!pre_emit)
                begin
                    hash_next = (hash_reg << 1) + rd_a_data - rd_b_data;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin_go)
        begin
            n_next     = post_emit ? 24'd0 : n1;
            start_next = post_emit ? (fin_eos ? 40'd0 : start_b + {16'd0, n1}) : start_b;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            hash_reg        <= 32'd0;
            n_reg           <= 24'd0;
            start_reg       <= 40'd0;
            rb_cnt_reg      <= '0;
            min_len_reg     <= 24'd2048;
            max_size_reg    <= 24'd65536;
            window_size_reg <= 7'd48;
            cut_mask_reg    <= 32'd8191;
            qv_reg          <= 2'b00;
        end
        else
        begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            n_reg      <= n_next;
            start_reg  <= start_next;
            rb_cnt_reg <= rb_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MIN_SIZE:    min_len_reg     <= cfg_data[23:0];
                    CFG_MAX_SIZE:    max_size_reg    <= cfg_data[23:0];
                    CFG_WINDOW_SIZE: window_size_reg <= cfg_data[6:0];
                    CFG_CUT_MASK:    cut_mask_reg    <= cfg_data;
                    default:         ;
                endcase
            end
            priority if (fin_go)
            begin
                qv_reg <= {pre_emit && post_emit, pre_emit || post_emit};
            end
            else if (out_acc)
            begin
                qv_reg <= {1'b0, qv_reg[1]};
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byte_reg <= byte_value;
            eos_reg  <= end_of_stream;
        end
        priority if (fin_go)
        begin
            q0_reg <= pre_emit ? pre_res : post_res;
            q1_reg <= post_res;
        end
        else if (out_acc)
        begin
            q0_reg <= q1_reg;
        end
    end

    `ASSERT_SAME(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_SAME(a_queue_order, clk, rst_n, qv_reg[1], qv_reg[0])
    `ASSERT_NEXT(a_rb_step, clk, rst_n, state_reg == S_RB_ACC,
                 state_reg == S_RB_RD || state_reg == S_LOOK)
    `ASSERT_NEXT(a_roll_done, clk, rst_n, state_reg == S_ROLL, state_reg == S_IDLE)
endmodule
`default_nettype wire

>>> sv/ghcc_cell.sv
// One history cell of the byte shift line.
// Depends on ghcc_pkg only by convention; holds one byte and passes it on.
`default_nettype none
module ghcc_cell
    import ghcc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic [7:0] byte_in,
    output logic      [7:0] byte_out
);
    logic [7:0] byte_reg;

    // Take the neighbor's byte whenever the line advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
endmodule
`default_nettype wire

>>> sv/ghcc_gear_ram.sv
// Gear table: 256 x 32 memory with one write port and two registered reads.
// Uses ghcc_pkg; instantiated by the top level.
`default_nettype none
module ghcc_gear_ram
    import ghcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [7:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic [7:0]  rd_a_addr,
    input  wire logic [7:0]  rd_b_addr,
    output logic      [31:0] rd_a_data,
    output logic      [31:0] rd_b_data
);
    logic [31:0] mem [256];

    // Write and read ports, read data registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end
endmodule
`default_nettype wire
